[rtl/crfw_pkg.sv]
// ----------------------------------------------------------------------------
// crfw_pkg
// Shared types and constants of the clipped rectangle fill writer.
// ----------------------------------------------------------------------------
package crfw_pkg;

	localparam int unsigned CRFW_ROW_PITCH = 320;

	localparam logic [15:0] CLIP_LEFT_RST   = 16'd0;
	localparam logic [15:0] CLIP_RIGHT_RST  = 16'd320;
	localparam logic [15:0] BAND_TOP_RST    = 16'd0;
	localparam logic [15:0] BAND_BOTTOM_RST = 16'd200;
	localparam logic [15:0] BUFFER_BASE_RST = 16'd0;

	localparam int unsigned CFG_IDX_W = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_TOP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_BOTTOM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BASE = 3'd4;

	typedef enum logic {
		KIND_START   = 1'b0,
		KIND_ADVANCE = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		PH_LEAD  = 2'd0,
		PH_DWORD = 2'd1,
		PH_TRAIL = 2'd2
	} phase_t;

	typedef struct packed {
		logic [15:0] clip_left;
		logic [15:0] clip_right;
		logic [15:0] band_top;
		logic [15:0] band_bottom;
		logic [15:0] buffer_base;
	} cfg_t;

	typedef struct packed {
		logic        empty;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] w;
		logic [7:0]  h;
	} clip_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  color;
		clip_t       clip;
	} stage_t;

	typedef struct packed {
		logic        write_valid;
		logic [15:0] write_address;
		logic [31:0] write_data;
		logic        write_is_dword;
		logic        last_write;
		logic        busy_res;
	} result_t;

endpackage

[rtl/crfw_channels.sv]
// ----------------------------------------------------------------------------
// crfw channels
// Valid/ready channel interfaces for items, results and register writes.
// ----------------------------------------------------------------------------
interface crfw_item_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  fill_color;
	logic [15:0] rect_x;
	logic [15:0] rect_y;
	logic [15:0] rect_width;
	logic [15:0] rect_height;

	modport source (output valid, kind, fill_color, rect_x, rect_y, rect_width,
		rect_height, input ready);
	modport sink (input valid, kind, fill_color, rect_x, rect_y, rect_width,
		rect_height, output ready);
endinterface

interface crfw_result_if;
	logic        valid;
	logic        ready;
	logic        write_valid;
	logic [15:0] write_address;
	logic [31:0] write_data;
	logic        write_is_dword;
	logic        last_write;
	logic        busy_res;

	modport source (output valid, write_valid, write_address, write_data,
		write_is_dword, last_write, busy_res, input ready);
	modport sink (input valid, write_valid, write_address, write_data,
		write_is_dword, last_write, busy_res, output ready);
endinterface

interface crfw_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/crfw_clip.sv]
// ----------------------------------------------------------------------------
// crfw_clip
// Clips an incoming rectangle against the column window and the row band.
// ----------------------------------------------------------------------------
module crfw_clip (
	input  crfw_pkg::cfg_t  cfg,
	input  logic [15:0]     x,
	input  logic [15:0]     y,
	input  logic [15:0]     w,
	input  logic [15:0]     h,
	output crfw_pkg::clip_t clip
);
	import crfw_pkg::*;

	typedef struct packed {
		logic        empty;
		logic [15:0] pos;
		logic [15:0] len;
	} axis_t;

	// One axis: clip against an inclusive low limit, then an exclusive high
	// limit, all in wrapping 16-bit arithmetic with signed compares.
	function automatic axis_t clip_axis(input logic [15:0] pos, input logic [15:0] len,
			input logic [15:0] lo, input logic [15:0] hi);
		logic [15:0] d_lo;
		logic [15:0] d_hi;
		logic [15:0] span;
		logic [16:0] ext_lo;
		logic [17:0] ext_hi;
		axis_t       r;
		r.empty = len[15] || (len == 16'd0);
		r.pos   = pos;
		r.len   = len;
		d_lo    = pos - lo;
		ext_lo  = {1'b0, len} + {d_lo[15], d_lo};
		if (d_lo[15]) begin
			if (ext_lo[16] || (ext_lo == 17'd0)) r.empty = 1'b1;
			r.len = ext_lo[15:0];
			r.pos = lo;
		end
		span   = r.pos + r.len;
		d_hi   = span - hi;
		ext_hi = {2'b00, r.len} - {{2{d_hi[15]}}, d_hi};
		if ($signed(span) > $signed(hi)) begin
			if (ext_hi[17] || (ext_hi == 18'd0)) r.empty = 1'b1;
			r.len = ext_hi[15:0];
		end
		return r;
	endfunction

	axis_t horiz;
	axis_t vert;

	always_comb begin
		horiz = clip_axis(x, w, cfg.clip_left, cfg.clip_right);
		vert  = clip_axis(y, h, cfg.band_top, cfg.band_bottom);
		clip.empty = horiz.empty || vert.empty;
		clip.x     = horiz.pos;
		clip.w     = horiz.len;
		clip.y     = vert.pos;
		clip.h     = vert.len[7:0];
	end

endmodule

[rtl/crfw_walk.sv]
// ----------------------------------------------------------------------------
// crfw_walk
// Fill state and address walker: sets up a fill from a clipped rectangle and
// produces one write per advance while a fill is active, row by row.
// ----------------------------------------------------------------------------
module crfw_walk #(
	parameter int unsigned ROW_PITCH = crfw_pkg::CRFW_ROW_PITCH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  crfw_pkg::stage_t  item,
	input  logic [15:0]       base,
	output crfw_pkg::result_t res
);
	import crfw_pkg::*;

	localparam logic [15:0] PITCH = 16'(ROW_PITCH);

	typedef struct packed {
		phase_t      ph;
		logic [13:0] cnt;
	} entry_t;

	// First phase of a row that has a nonzero count.
	function automatic entry_t enter_row(input logic [1:0] lead, input logic [13:0] dw,
			input logic [2:0] trail);
		entry_t e;
		if (lead != 2'd0) begin
			e.ph  = PH_LEAD;
			e.cnt = {12'd0, lead};
		end else if (dw != 14'd0) begin
			e.ph  = PH_DWORD;
			e.cnt = dw;
		end else begin
			e.ph  = PH_TRAIL;
			e.cnt = {11'd0, trail};
		end
		return e;
	endfunction

	logic        active_q, active_d;
	phase_t      phase_q, phase_d;
	logic [13:0] pcl_q, pcl_d;
	logic [8:0]  rows_left_q, rows_left_d;
	logic [15:0] row_start_q, row_start_d;
	logic [15:0] wp_q, wp_d;
	logic [1:0]  lead_q, lead_d;
	logic [13:0] dw_q, dw_d;
	logic [2:0]  trail_q, trail_d;
	logic [7:0]  color_q, color_d;

	logic [15:0] offset;
	logic [1:0]  start_lead;
	logic [13:0] start_dw;
	logic [2:0]  start_trail;
	logic [8:0]  start_rows;
	logic [13:0] dw_adj;
	logic [1:0]  rem_lead;
	logic        is_dword;
	logic        advance;

	assign is_dword = (phase_q == PH_DWORD);
	assign advance  = step && (item.kind == KIND_ADVANCE) && active_q;

	// Geometry of a new fill.
	always_comb begin
		offset = base + {item.clip.y[7:0], item.clip.y[15:8]}
			+ {item.clip.y[9:0], 6'd0} + item.clip.x;
		dw_adj   = item.clip.w[15:2]
			- {13'd0, (item.clip.w[1:0] < offset[1:0])};
		rem_lead = item.clip.w[1:0] - offset[1:0];
		if (item.clip.w[15:2] == 14'd0) begin
			start_lead  = 2'd0;
			start_dw    = 14'd0;
			start_trail = {1'b0, item.clip.w[1:0]};
		end else if (dw_adj == 14'd0) begin
			// Too short for a whole dword once aligned: all bytes.
			start_lead  = 2'd0;
			start_dw    = 14'd0;
			start_trail = {1'b0, rem_lead} + {1'b0, offset[1:0]};
		end else begin
			start_lead  = offset[1:0];
			start_dw    = dw_adj;
			start_trail = {1'b0, rem_lead};
		end
		start_rows = (item.clip.h == 8'd0) ? 9'd256 : {1'b0, item.clip.h};
	end

	// Next state.
	always_comb begin
		entry_t e;
		logic   row_end;
		active_d    = active_q;
		phase_d     = phase_q;
		pcl_d       = pcl_q;
		rows_left_d = rows_left_q;
		row_start_d = row_start_q;
		wp_d        = wp_q;
		lead_d      = lead_q;
		dw_d        = dw_q;
		trail_d     = trail_q;
		color_d     = color_q;
		row_end     = 1'b0;
		e           = enter_row(lead_q, dw_q, trail_q);
		if (step && (item.kind == KIND_START)) begin
			e           = enter_row(start_lead, start_dw, start_trail);
			active_d    = !item.clip.empty;
			color_d     = item.color;
			lead_d      = start_lead;
			dw_d        = start_dw;
			trail_d     = start_trail;
			rows_left_d = start_rows;
			row_start_d = offset;
			wp_d        = offset;
			phase_d     = e.ph;
			pcl_d       = e.cnt;
		end else if (advance) begin
			wp_d  = wp_q + (is_dword ? 16'd4 : 16'd1);
			pcl_d = pcl_q - 14'd1;
			if (pcl_q == 14'd1) begin
				unique case (phase_q)
					PH_LEAD: begin
						if (dw_q != 14'd0) begin
							phase_d = PH_DWORD;
							pcl_d   = dw_q;
						end else if (trail_q != 3'd0) begin
							phase_d = PH_TRAIL;
							pcl_d   = {11'd0, trail_q};
						end else begin
							row_end = 1'b1;
						end
					end
					PH_DWORD: begin
						if (trail_q != 3'd0) begin
							phase_d = PH_TRAIL;
							pcl_d   = {11'd0, trail_q};
						end else begin
							row_end = 1'b1;
						end
					end
					default: row_end = 1'b1;
				endcase
			end
			if (row_end) begin
				if (rows_left_q == 9'd1) begin
					active_d    = 1'b0;
					phase_d     = PH_LEAD;
					rows_left_d = 9'd0;
				end else begin
					rows_left_d = rows_left_q - 9'd1;
					row_start_d = row_start_q + PITCH;
					wp_d        = row_start_q + PITCH;
					phase_d     = e.ph;
					pcl_d       = e.cnt;
				end
			end
		end
	end

	// Result of the current item.
	always_comb begin
		res = '0;
		if (advance) begin
			res.write_valid    = 1'b1;
			res.write_address  = wp_q;
			res.write_data     = is_dword ? {4{color_q}} : {24'd0, color_q};
			res.write_is_dword = is_dword;
			res.last_write     = !active_d;
			res.busy_res       = active_d;
		end else if (step && (item.kind == KIND_START)) begin
			res.busy_res = !item.clip.empty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			phase_q     <= PH_LEAD;
			pcl_q       <= '0;
			rows_left_q <= '0;
			row_start_q <= '0;
			wp_q        <= '0;
			lead_q      <= '0;
			dw_q        <= '0;
			trail_q     <= '0;
			color_q     <= '0;
		end else begin
			active_q    <= active_d;
			phase_q     <= phase_d;
			pcl_q       <= pcl_d;
			rows_left_q <= rows_left_d;
			row_start_q <= row_start_d;
			wp_q        <= wp_d;
			lead_q      <= lead_d;
			dw_q        <= dw_d;
			trail_q     <= trail_d;
			color_q     <= color_d;
		end
	end

	a_rows_live: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> rows_left_q != 9'd0)
		else $error("active fill with no rows left");

	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> pcl_q != 14'd0)
		else $error("active fill parked on an empty phase");

	a_lead_short: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && (phase_q == PH_LEAD) |-> pcl_q < 14'd4)
		else $error("leading byte count beyond alignment");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step && (item.kind == KIND_ADVANCE) && !active_q |=> !active_q && $stable(wp_q))
		else $error("advance while idle changed the fill state");

endmodule

[rtl/clipped_rect_fill_writer.sv]
// ----------------------------------------------------------------------------
// clipped_rect_fill_writer
// Clipped rectangle fill: turns start and advance items into framebuffer
// byte and dword writes.
// ----------------------------------------------------------------------------
// The block takes one item per clock when the result side does not stall and
// returns exactly one result per item. An item is clipped as it enters the
// input register, then one pass of logic computes the write and the next fill
// state into the output register, which offers the result; the input register
// holds its item while the output register is full and not being drained. The
// configuration port is always ready; registers are meant to be written only
// while no fill transaction is in flight.
module clipped_rect_fill_writer #(
	parameter int unsigned ROW_PITCH = crfw_pkg::CRFW_ROW_PITCH
) (
	input  logic          clk,
	input  logic          arst_n,
	crfw_item_if.sink     item,
	crfw_result_if.source result,
	crfw_cfg_if.sink      cfg
);
	import crfw_pkg::*;

	cfg_t    cfg_q;
	clip_t   clip;
	logic    valid_s1;
	stage_t  stage_s1;
	logic    step;
	result_t walk_res;
	result_t res_q;
	logic    res_valid_q;

	// Register file.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clip_left   <= CLIP_LEFT_RST;
			cfg_q.clip_right  <= CLIP_RIGHT_RST;
			cfg_q.band_top    <= BAND_TOP_RST;
			cfg_q.band_bottom <= BAND_BOTTOM_RST;
			cfg_q.buffer_base <= BUFFER_BASE_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_CLIP_LEFT:   cfg_q.clip_left   <= cfg.data;
				REG_CLIP_RIGHT:  cfg_q.clip_right  <= cfg.data;
				REG_BAND_TOP:    cfg_q.band_top    <= cfg.data;
				REG_BAND_BOTTOM: cfg_q.band_bottom <= cfg.data;
				REG_BUFFER_BASE: cfg_q.buffer_base <= cfg.data;
				default: ;
			endcase
		end
	end

	crfw_clip u_clip (
		.cfg  (cfg_q),
		.x    (item.rect_x),
		.y    (item.rect_y),
		.w    (item.rect_width),
		.h    (item.rect_height),
		.clip (clip)
	);

	// The walker steps whenever the input register holds an item and the output register is free or being drained.
	assign step       = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			stage_s1.kind  <= kind_t'(item.kind);
			stage_s1.color <= item.fill_color;
			stage_s1.clip  <= clip;
		end
	end

	crfw_walk #(
		.ROW_PITCH (ROW_PITCH)
	) u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (stage_s1),
		.base   (cfg_q.buffer_base),
		.res    (walk_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= walk_res;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.write_valid    = res_q.write_valid;
	assign result.write_address  = res_q.write_address;
	assign result.write_data     = res_q.write_data;
	assign result.write_is_dword = res_q.write_is_dword;
	assign result.last_write     = res_q.last_write;
	assign result.busy_res       = res_q.busy_res;

	a_start_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		step && (stage_s1.kind == KIND_START) |=> res_valid_q && !res_q.write_valid)
		else $error("start transaction produced a write");

	a_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && (stage_s1.kind == KIND_START) && stage_s1.clip.empty |=> !res_q.busy_res)
		else $error("clipped-away rectangle reported busy");

	a_last_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.last_write |-> res_q.write_valid && !res_q.busy_res)
		else $error("final write still reports pending writes");

endmodule
